/* rtl/pips_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_pkg
// Shared constants and codes for the point-in-polygon shape store.
// ----------------------------------------------------------------------------
package pips_pkg;

    localparam int MAX_SHAPES = 8;
    localparam int MAX_VERTS  = 64;
    localparam int COORD_W    = 16;
    localparam int MIN_POLY   = 3;

    localparam int SHAPE_BITS = $clog2(MAX_SHAPES);
    localparam int VERT_BITS  = $clog2(MAX_VERTS);
    localparam int CNT_BITS   = $clog2(MAX_SHAPES + 1);
    localparam int LEN_BITS   = $clog2(MAX_VERTS + 1);
    localparam int ADDR_BITS  = SHAPE_BITS + VERT_BITS;
    localparam int DEPTH      = MAX_SHAPES * MAX_VERTS;
    localparam int WORD_W     = 2 * COORD_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_OPEN   = 2'd1,
        OP_APPEND = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOSHAPE = 2'd3
    } t_status;

endpackage

/* rtl/point_in_polygon_set.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_set
// Store of polygons with a crossing-number point query, one shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_operation, i_coord_x, i_coord_y
// out       source     o_out_valid / i_out_stall o_inside_res, o_status
// cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Clear and open are handled in the idle state; append runs over a shape of n
// vertices (one duplicate compare per vertex, one RAM read port).
// A query walks each shape of at least three vertices, edge by edge: each edge
// uses the single multiplier twice and is evaluated in S_QM1, S_QM2, S_QM3, S_QEV.
// One item at a time; the input stalls until the result has been taken.
// Synchronous active-low reset clears shape count, lengths and origins.
// ----------------------------------------------------------------------------
module point_in_polygon_set (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [pips_pkg::COORD_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_operation,
    input  logic signed [pips_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [pips_pkg::COORD_W-1:0] i_coord_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_inside_res,
    output logic [1:0]                          o_status
);
    import pips_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DUP    = 10'b00_0000_0010,
        S_DUPEND = 10'b00_0000_0100,
        S_APPW   = 10'b00_0000_1000,
        S_QSH    = 10'b00_0001_0000,
        S_QPRV   = 10'b00_0010_0000,
        S_QM1    = 10'b00_0100_0000,
        S_QM2    = 10'b00_1000_0000,
        S_QM3    = 10'b01_0000_0000,
        S_QEV    = 10'b10_0000_0000
    } t_state;

    localparam int PROD_W = 2 * COORD_W + 3;

    t_state                       r_state;
    logic signed [COORD_W-1:0]    r_origin_x, r_origin_y;
    logic [LEN_BITS-1:0]          r_len [MAX_SHAPES];
    logic [CNT_BITS-1:0]          r_count;
    logic [CNT_BITS-1:0]          r_s;
    logic [LEN_BITS-1:0]          r_i;
    logic signed [COORD_W-1:0]    r_x, r_y;
    logic signed [COORD_W:0]      r_px, r_py;
    logic                         r_cmp, r_dup, r_odd;
    logic signed [COORD_W-1:0]    r_ax, r_ay, r_bx, r_by;
    logic signed [COORD_W:0]      r_dx, r_dy;
    logic signed [COORD_W+1:0]    r_ex, r_ey;
    logic                         r_inbox, r_crosses;
    logic signed [PROD_W-1:0]     r_prod, r_p1;
    logic                         r_out_valid, r_inside;
    t_status                      r_status;

    logic                         w_accept;
    logic [LEN_BITS-1:0]          w_len;
    logic [ADDR_BITS-1:0]         w_raddr;
    logic [WORD_W-1:0]            w_rdata;
    logic                         w_we;
    logic signed [COORD_W-1:0]    w_bx, w_by, w_lox, w_hix, w_loy, w_hiy;
    logic signed [COORD_W:0]      w_ma;
    logic signed [COORD_W+1:0]    w_mb;
    logic signed [PROD_W-1:0]     w_mul;
    logic                         w_onedge, w_flip, w_odd_nx;
    logic [LEN_BITS-1:0]          w_i_nx;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_len    = r_len[r_s[SHAPE_BITS-1:0]];
    assign w_i_nx   = r_i + LEN_BITS'(1);

    always_comb begin
        unique case (r_state)
            S_QSH:   w_raddr = {r_s[SHAPE_BITS-1:0], VERT_BITS'(w_len - LEN_BITS'(1))};
            S_QEV:   w_raddr = {r_s[SHAPE_BITS-1:0], w_i_nx[VERT_BITS-1:0]};
            default: w_raddr = {r_s[SHAPE_BITS-1:0], r_i[VERT_BITS-1:0]};
        endcase
    end

    assign w_we = (r_state == S_APPW) && !r_dup && (w_len < LEN_BITS'(MAX_VERTS));

    pips_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_s[SHAPE_BITS-1:0], w_len[VERT_BITS-1:0]}),
        .i_wdata ({r_x, r_y}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Edge geometry from the vertex just read
    assign w_bx  = signed'(w_rdata[WORD_W-1:COORD_W]);
    assign w_by  = signed'(w_rdata[COORD_W-1:0]);
    assign w_lox = (r_ax < w_bx) ? r_ax : w_bx;
    assign w_hix = (r_ax < w_bx) ? w_bx : r_ax;
    assign w_loy = (r_ay < w_by) ? r_ay : w_by;
    assign w_hiy = (r_ay < w_by) ? w_by : r_ay;

    // Shared multiplier: dx*ey first, then dy*ex
    assign w_ma  = (r_state == S_QM2) ? r_dx : r_dy;
    assign w_mb  = (r_state == S_QM2) ? r_ey : r_ex;
    assign w_mul = PROD_W'(w_ma) * PROD_W'(w_mb);

    // r_p1 = (bx-ax)(py-ay), r_prod = (by-ay)(px-ax); cross = r_p1 - r_prod
    assign w_onedge = (r_p1 == r_prod) && r_inbox;
    assign w_flip   = r_crosses && ((r_dy > 0) ? (r_prod < r_p1) : (r_prod > r_p1));
    assign w_odd_nx = r_odd ^ w_flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cmp       <= 1'b0;
            for (int k = 0; k < MAX_SHAPES; k++) begin
                r_len[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_origin_y <= signed'(i_cfg_data);
                end else begin
                    r_origin_x <= signed'(i_cfg_data);
                end
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_cmp && (w_rdata == {r_x, r_y})) begin
                r_dup <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x      <= i_coord_x;
                        r_y      <= i_coord_y;
                        r_px     <= (COORD_W+1)'(i_coord_x) - (COORD_W+1)'(r_origin_x);
                        r_py     <= (COORD_W+1)'(i_coord_y) - (COORD_W+1)'(r_origin_y);
                        r_i      <= '0;
                        r_dup    <= 1'b0;
                        r_inside <= 1'b0;
                        r_status <= ST_DONE;
                        unique case (t_op'(i_operation))
                            OP_CLEAR: begin
                                r_count <= '0;
                                for (int k = 0; k < MAX_SHAPES; k++) begin
                                    r_len[k] <= '0;
                                end
                                r_out_valid <= 1'b1;
                            end
                            OP_OPEN: begin
                                if (r_count >= CNT_BITS'(MAX_SHAPES)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_len[r_count[SHAPE_BITS-1:0]] <= '0;
                                    r_count <= r_count + CNT_BITS'(1);
                                end
                                r_out_valid <= 1'b1;
                            end
                            OP_APPEND: begin
                                if (r_count == '0) begin
                                    r_status    <= ST_NOSHAPE;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_s     <= r_count - CNT_BITS'(1);
                                    r_state <= S_DUP;
                                end
                            end
                            OP_QUERY: begin
                                r_s     <= '0;
                                r_state <= S_QSH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DUP: begin
                    if (r_i < w_len) begin
                        r_cmp <= 1'b1;
                        r_i   <= w_i_nx;
                    end else begin
                        r_cmp   <= 1'b0;
                        r_state <= S_DUPEND;
                    end
                end
                S_DUPEND: begin
                    r_cmp   <= 1'b0;
                    r_state <= S_APPW;
                end
                S_APPW: begin
                    if (r_dup) begin
                        r_status <= ST_DUP;
                    end else if (w_len >= LEN_BITS'(MAX_VERTS)) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_len[r_s[SHAPE_BITS-1:0]] <= w_len + LEN_BITS'(1);
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_QSH: begin
                    if (r_s >= r_count) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (w_len < LEN_BITS'(MIN_POLY)) begin
                        r_s <= r_s + CNT_BITS'(1);
                    end else begin
                        r_i     <= '0;
                        r_odd   <= 1'b0;
                        r_state <= S_QPRV;
                    end
                end
                S_QPRV: begin
                    // last vertex closes the ring
                    r_ax    <= w_bx;
                    r_ay    <= w_by;
                    r_state <= S_QM1;
                end
                S_QM1: begin
                    r_bx      <= w_bx;
                    r_by      <= w_by;
                    r_dx      <= (COORD_W+1)'(w_bx) - (COORD_W+1)'(r_ax);
                    r_dy      <= (COORD_W+1)'(w_by) - (COORD_W+1)'(r_ay);
                    r_ex      <= (COORD_W+2)'(r_px) - (COORD_W+2)'(r_ax);
                    r_ey      <= (COORD_W+2)'(r_py) - (COORD_W+2)'(r_ay);
                    r_inbox   <= (r_px >= (COORD_W+1)'(w_lox)) && (r_px <= (COORD_W+1)'(w_hix))
                              && (r_py >= (COORD_W+1)'(w_loy)) && (r_py <= (COORD_W+1)'(w_hiy));
                    r_crosses <= (((COORD_W+1)'(r_ay) > r_py) != ((COORD_W+1)'(w_by) > r_py));
                    r_state   <= S_QM2;
                end
                S_QM2: begin
                    r_prod  <= w_mul;
                    r_state <= S_QM3;
                end
                S_QM3: begin
                    r_p1    <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_QEV;
                end
                S_QEV: begin
                    r_ax  <= r_bx;
                    r_ay  <= r_by;
                    r_odd <= w_odd_nx;
                    r_i   <= w_i_nx;
                    if (w_onedge || (w_i_nx == w_len && w_odd_nx)) begin
                        r_inside    <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (w_i_nx == w_len) begin
                        r_s     <= r_s + CNT_BITS'(1);
                        r_state <= S_QSH;
                    end else begin
                        r_state <= S_QM1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_status     = r_status;

    // A pending result only ever sits while the sequencer is idle
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE))
        else $error("result pending while sequencer busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_SHAPES))
        else $error("shape count beyond capacity");

    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QM1 || r_state == S_QEV) |-> (r_i < w_len))
        else $error("edge index beyond shape length");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_op'(i_operation) == OP_CLEAR)) |=> r_out_valid)
        else $error("clear item gave no result");

endmodule

/* rtl/pips_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pips_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pips_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
